// File: hdl/json_token_structure_checker_top_assert.svh
// Assertion macros used by the checker file of the token structure checker.
`ifndef JSON_TOKEN_STRUCTURE_CHECKER_TOP_ASSERT_SVH
`define JSON_TOKEN_STRUCTURE_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define JTSC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("jtsc assertion failed");

// Next-cycle implication, disabled during reset.
`define JTSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("jtsc assertion failed");

`endif

// File: hdl/jtsc_pkg.sv
// Types, codes and constants of the JSON token structure checker.
package jtsc_pkg;

  localparam int MAX_DEPTH = 64;
  localparam int LEVEL_W   = $clog2(MAX_DEPTH);
  localparam int DEPTH_W   = 7;

  localparam logic [3:0] TK_OSTART = 4'd0;
  localparam logic [3:0] TK_OEND   = 4'd1;
  localparam logic [3:0] TK_STRING = 4'd2;
  localparam logic [3:0] TK_COLON  = 4'd3;
  localparam logic [3:0] TK_NULL   = 4'd4;
  localparam logic [3:0] TK_BOOL   = 4'd5;
  localparam logic [3:0] TK_NUMBER = 4'd6;
  localparam logic [3:0] TK_ASTART = 4'd7;
  localparam logic [3:0] TK_AEND   = 4'd8;
  localparam logic [3:0] TK_COMMA  = 4'd9;

  typedef enum logic [3:0] {
    PH_INIT   = 4'd0,
    PH_OSTART = 4'd1,
    PH_KEY    = 4'd2,
    PH_COLON  = 4'd3,
    PH_VALUE  = 4'd4,
    PH_ARRAY  = 4'd5,
    PH_ADELIM = 4'd6,
    PH_OEND   = 4'd7,
    PH_COMMA  = 4'd8,
    PH_END    = 4'd9,
    PH_ERROR  = 4'd10
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_UNEXPECTED = 3'd1,
    ERR_DEPTH      = 3'd2,
    ERR_UNCLOSED   = 3'd3,
    ERR_AFTER_END  = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_OK   = 2'd1,
    ST_FAIL = 2'd2
  } status_e;

  typedef struct packed {
    logic [3:0] token_kind;
    logic       last_token;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         error_kind;
    logic [DEPTH_W-1:0] depth;
  } out_item_t;

  function automatic logic is_scalar(input logic [3:0] t);
    return (t == TK_STRING) || (t == TK_NULL) || (t == TK_BOOL) || (t == TK_NUMBER);
  endfunction

endpackage

// File: hdl/json_token_structure_checker_top.sv
// Top level of the JSON token structure checker: phase machine and result register.
// Takes one token kind per item and returns one status item per token, one item
// per clock cycle while the output is not stalled: the phase, nesting level
// and error registers are updated in the cycle a token is accepted, and the result
// lands in a single output register that accepts a new item in the same cycle its
// held result is taken. A failure sticks until the token marked last, after which
// the checker starts over for the next document. The block has no clearing pass.
module json_token_structure_checker_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jtsc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jtsc_pkg::out_item_t out_data_o
);

  localparam int LW = jtsc_pkg::LEVEL_W;
  localparam logic [LW:0] MaxDepthC = (LW + 1)'(jtsc_pkg::MAX_DEPTH);

  jtsc_pkg::phase_e    phase_q, phase_d;
  logic [LW-1:0]       level_q, level_d;
  jtsc_pkg::err_e      err_q, err_d;
  jtsc_pkg::out_item_t res_d, out_data_q;
  logic                out_valid_q;
  logic                in_fire;

  logic [LW-1:0] close_lvl;
  logic [LW:0]   level_inc;
  logic          open_ok;
  logic [3:0]    tk;

  assign tk        = in_data_i.token_kind;
  assign level_inc = {1'b0, level_q} + (LW + 1)'(1);
  assign open_ok   = level_inc < MaxDepthC;
  assign close_lvl = (level_q == '0) ? '0 : level_q - LW'(1);

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Next phase, level and error for the current token
  always_comb begin
    phase_d = phase_q;
    level_d = level_q;
    err_d   = err_q;
    case (phase_q)
      jtsc_pkg::PH_INIT: begin
        if (tk == jtsc_pkg::TK_OSTART) begin
          if (open_ok) begin
            level_d = level_inc[LW-1:0];
            phase_d = jtsc_pkg::PH_OSTART;
          end else begin
            phase_d = jtsc_pkg::PH_ERROR;
            err_d   = jtsc_pkg::ERR_DEPTH;
          end
        end else begin
          phase_d = jtsc_pkg::PH_ERROR;
          err_d   = jtsc_pkg::ERR_UNEXPECTED;
        end
      end
      jtsc_pkg::PH_OSTART, jtsc_pkg::PH_COMMA: begin
        if (tk == jtsc_pkg::TK_STRING) begin
          phase_d = jtsc_pkg::PH_KEY;
        end else if (tk == jtsc_pkg::TK_OEND && phase_q == jtsc_pkg::PH_OSTART) begin
          level_d = close_lvl;
          phase_d = (close_lvl == '0) ? jtsc_pkg::PH_END : jtsc_pkg::PH_OEND;
        end else if (tk == jtsc_pkg::TK_OSTART && phase_q == jtsc_pkg::PH_COMMA) begin
          if (open_ok) begin
            level_d = level_inc[LW-1:0];
            phase_d = jtsc_pkg::PH_OSTART;
          end else begin
            phase_d = jtsc_pkg::PH_ERROR;
            err_d   = jtsc_pkg::ERR_DEPTH;
          end
        end else begin
          phase_d = jtsc_pkg::PH_ERROR;
          err_d   = jtsc_pkg::ERR_UNEXPECTED;
        end
      end
      jtsc_pkg::PH_KEY: begin
        if (tk == jtsc_pkg::TK_COLON) begin
          phase_d = jtsc_pkg::PH_COLON;
        end else begin
          phase_d = jtsc_pkg::PH_ERROR;
          err_d   = jtsc_pkg::ERR_UNEXPECTED;
        end
      end
      jtsc_pkg::PH_COLON: begin
        if (jtsc_pkg::is_scalar(tk)) begin
          phase_d = jtsc_pkg::PH_VALUE;
        end else if (tk == jtsc_pkg::TK_ASTART) begin
          phase_d = jtsc_pkg::PH_ARRAY;
        end else if (tk == jtsc_pkg::TK_OSTART) begin
          if (open_ok) begin
            level_d = level_inc[LW-1:0];
            phase_d = jtsc_pkg::PH_OSTART;
          end else begin
            phase_d = jtsc_pkg::PH_ERROR;
            err_d   = jtsc_pkg::ERR_DEPTH;
          end
        end else begin
          phase_d = jtsc_pkg::PH_ERROR;
          err_d   = jtsc_pkg::ERR_UNEXPECTED;
        end
      end
      jtsc_pkg::PH_VALUE: begin
        if (tk == jtsc_pkg::TK_COMMA) begin
          phase_d = jtsc_pkg::PH_COMMA;
        end else if (tk == jtsc_pkg::TK_OEND) begin
          level_d = close_lvl;
          phase_d = (close_lvl == '0) ? jtsc_pkg::PH_END : jtsc_pkg::PH_OEND;
        end else begin
          phase_d = jtsc_pkg::PH_ERROR;
          err_d   = jtsc_pkg::ERR_UNEXPECTED;
        end
      end
      jtsc_pkg::PH_ARRAY: begin
        if (jtsc_pkg::is_scalar(tk)) begin
          phase_d = jtsc_pkg::PH_ADELIM;
        end else begin
          phase_d = jtsc_pkg::PH_ERROR;
          err_d   = jtsc_pkg::ERR_UNEXPECTED;
        end
      end
      jtsc_pkg::PH_ADELIM: begin
        if (tk == jtsc_pkg::TK_COMMA) begin
          phase_d = jtsc_pkg::PH_ARRAY;
        end else if (tk == jtsc_pkg::TK_AEND) begin
          phase_d = jtsc_pkg::PH_VALUE;
        end else begin
          phase_d = jtsc_pkg::PH_ERROR;
          err_d   = jtsc_pkg::ERR_UNEXPECTED;
        end
      end
      jtsc_pkg::PH_OEND: begin
        // Anything but a comma closes one more level first
        if (level_q == '0) begin
          phase_d = jtsc_pkg::PH_END;
        end else if (tk == jtsc_pkg::TK_COMMA) begin
          phase_d = jtsc_pkg::PH_COMMA;
        end else begin
          level_d = close_lvl;
          if (close_lvl == '0) begin
            phase_d = jtsc_pkg::PH_END;
          end else if (tk == jtsc_pkg::TK_OEND) begin
            phase_d = jtsc_pkg::PH_OEND;
          end else begin
            phase_d = jtsc_pkg::PH_ERROR;
            err_d   = jtsc_pkg::ERR_UNEXPECTED;
          end
        end
      end
      jtsc_pkg::PH_END: begin
        phase_d = jtsc_pkg::PH_ERROR;
        err_d   = jtsc_pkg::ERR_AFTER_END;
      end
      jtsc_pkg::PH_ERROR: begin
        phase_d = jtsc_pkg::PH_ERROR;
      end
      default: begin
        phase_d = jtsc_pkg::PH_ERROR;
        err_d   = jtsc_pkg::ERR_UNEXPECTED;
      end
    endcase
  end

  // Result item for the current token
  always_comb begin
    res_d.depth = jtsc_pkg::DEPTH_W'(level_d);
    if (phase_d == jtsc_pkg::PH_ERROR) begin
      res_d.status     = jtsc_pkg::ST_FAIL;
      res_d.error_kind = err_d;
    end else if (in_data_i.last_token) begin
      if (level_d != '0) begin
        res_d.status     = jtsc_pkg::ST_FAIL;
        res_d.error_kind = jtsc_pkg::ERR_UNCLOSED;
      end else begin
        res_d.status     = jtsc_pkg::ST_OK;
        res_d.error_kind = jtsc_pkg::ERR_NONE;
      end
    end else begin
      res_d.status     = jtsc_pkg::ST_BUSY;
      res_d.error_kind = jtsc_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= jtsc_pkg::PH_INIT;
      level_q     <= '0;
      err_q       <= jtsc_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        // Start over after the last token of a document
        if (in_data_i.last_token) begin
          phase_q <= jtsc_pkg::PH_INIT;
          level_q <= '0;
          err_q   <= jtsc_pkg::ERR_NONE;
        end else begin
          phase_q <= phase_d;
          level_q <= level_d;
          err_q   <= err_d;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= res_d;
    end
  end

endmodule

// File: hdl/jtsc_assert_checker.sv
// Port-level assertions for the JSON token structure checker, bound to the top level.
`include "json_token_structure_checker_top_assert.svh"

module jtsc_assert_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input jtsc_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input jtsc_pkg::out_item_t out_data_o
);

  logic in_fire;
  logic out_stall;
  logic in_last;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign in_last   = in_data_i.last_token;

  // A stalled result item holds
  `JTSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o))

  // Every accepted item shows a result in the next cycle
  `JTSC_ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, in_fire, out_valid_o)

  // Busy and ok carry no error kind
  `JTSC_ASSERT_NOW(a_no_err_kind, clk_i, rst_ni,
    out_valid_o && out_data_o.status != jtsc_pkg::ST_FAIL,
    out_data_o.error_kind == jtsc_pkg::ERR_NONE)

  // A failure always names its kind
  `JTSC_ASSERT_NOW(a_fail_kind, clk_i, rst_ni,
    out_valid_o && out_data_o.status == jtsc_pkg::ST_FAIL,
    out_data_o.error_kind != jtsc_pkg::ERR_NONE)

  // Only the last item of a document can report ok; level zero is not checked here
  `JTSC_ASSERT_NEXT(a_ok_closed, clk_i, rst_ni, in_fire && !in_last,
    out_data_o.status != jtsc_pkg::ST_OK)

endmodule

bind json_token_structure_checker_top jtsc_assert_checker u_jtsc_assert_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: verif/tb_top.sv
// Testbench for the JSON token structure checker: directed table, then random documents.
`timescale 1ns / 1ps

module tb_top;
  import jtsc_pkg::*;

  localparam int N_ITEMS   = 900;
  localparam int QUIET_AT  = 760;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    logic [3:0] tok;
    logic       is_last;
    bit         typed;
    status_e    st;
    err_e       er;
    int         dep;
  } row_t;

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      out_ready = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  json_token_structure_checker_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Checker state as predicted from the token stream
  phase_e    cur_phase = PH_INIT;
  int        nest = 0;
  err_e      held_err = ERR_NONE;

  out_item_t verdict_q[$];
  in_item_t  doc_q[$];
  row_t      dir_rows[24];
  int        bad_results = 0;
  int        items_sent = 0;
  bit        quiet = 1'b0;
  int        tx_idle_pct = 0;

  function automatic void latch_fail(err_e kind);
    cur_phase = PH_ERROR;
    held_err  = kind;
  endfunction

  function automatic void open_level();
    if (nest + 1 >= MAX_DEPTH) begin
      latch_fail(ERR_DEPTH);
    end else begin
      nest++;
      cur_phase = PH_OSTART;
    end
  endfunction

  function automatic void close_level();
    if (nest > 0) nest--;
    cur_phase = (nest == 0) ? PH_END : PH_OEND;
  endfunction

  function automatic out_item_t predict_verdict(in_item_t it);
    logic [3:0] t;
    bit         scal;
    out_item_t  v;
    t    = it.token_kind;
    scal = t inside {TK_STRING, TK_NULL, TK_BOOL, TK_NUMBER};
    if (cur_phase != PH_ERROR) begin
      case (cur_phase)
        PH_INIT: begin
          if (t == TK_OSTART) open_level();
          else latch_fail(ERR_UNEXPECTED);
        end
        PH_OSTART, PH_COMMA: begin
          if (t == TK_STRING) cur_phase = PH_KEY;
          else if (t == TK_OEND && cur_phase == PH_OSTART) close_level();
          else if (t == TK_OSTART && cur_phase == PH_COMMA) open_level();
          else latch_fail(ERR_UNEXPECTED);
        end
        PH_KEY: begin
          if (t == TK_COLON) cur_phase = PH_COLON;
          else latch_fail(ERR_UNEXPECTED);
        end
        PH_COLON: begin
          if (scal) cur_phase = PH_VALUE;
          else if (t == TK_ASTART) cur_phase = PH_ARRAY;
          else if (t == TK_OSTART) open_level();
          else latch_fail(ERR_UNEXPECTED);
        end
        PH_VALUE: begin
          if (t == TK_COMMA) cur_phase = PH_COMMA;
          else if (t == TK_OEND) close_level();
          else latch_fail(ERR_UNEXPECTED);
        end
        PH_ARRAY: begin
          if (scal) cur_phase = PH_ADELIM;
          else latch_fail(ERR_UNEXPECTED);
        end
        PH_ADELIM: begin
          if (t == TK_COMMA) cur_phase = PH_ARRAY;
          else if (t == TK_AEND) cur_phase = PH_VALUE;
          else latch_fail(ERR_UNEXPECTED);
        end
        PH_OEND: begin
          // any token but a comma closes one more level first
          if (nest == 0) begin
            cur_phase = PH_END;
          end else if (t == TK_COMMA) begin
            cur_phase = PH_COMMA;
          end else begin
            nest--;
            if (nest == 0) cur_phase = PH_END;
            else if (t == TK_OEND) cur_phase = PH_OEND;
            else latch_fail(ERR_UNEXPECTED);
          end
        end
        PH_END: latch_fail(ERR_AFTER_END);
        default: latch_fail(ERR_UNEXPECTED);
      endcase
    end
    if (cur_phase == PH_ERROR) begin
      v.status     = ST_FAIL;
      v.error_kind = held_err;
    end else if (it.last_token) begin
      v.status     = (nest != 0) ? ST_FAIL : ST_OK;
      v.error_kind = (nest != 0) ? ERR_UNCLOSED : ERR_NONE;
    end else begin
      v.status     = ST_BUSY;
      v.error_kind = ERR_NONE;
    end
    v.depth = nest[DEPTH_W-1:0];
    if (it.last_token) begin
      cur_phase = PH_INIT;
      nest      = 0;
      held_err  = ERR_NONE;
    end
    return v;
  endfunction

  function automatic void report_bad(string what, out_item_t want, out_item_t got);
    bad_results++;
    if (bad_results <= MAX_SHOWN)
      $display("%0t: %s: expected status %0d kind %0d depth %0d, got status %0d kind %0d depth %0d",
               $time, what, want.status, want.error_kind, want.depth,
               got.status, got.error_kind, got.depth);
  endfunction

  // Hand one token over and wait for it to be taken
  task automatic send_token(input in_item_t it);
    if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic void push_tok(logic [3:0] t);
    in_item_t it;
    it.token_kind = t;
    it.last_token = 1'b0;
    doc_q.push_back(it);
  endfunction

  function automatic logic [3:0] any_scalar();
    case ($urandom_range(0, 3))
      0:       return TK_STRING;
      1:       return TK_NULL;
      2:       return TK_BOOL;
      default: return TK_NUMBER;
    endcase
  endfunction

  function automatic void gen_value(int lvl);
    int r;
    r = $urandom_range(0, 9);
    if (r >= 8 && lvl < 4) begin
      gen_object(lvl + 1);
    end else if (r >= 6) begin
      push_tok(TK_ASTART);
      repeat ($urandom_range(1, 4)) begin
        if (doc_q[$].token_kind != TK_ASTART) push_tok(TK_COMMA);
        push_tok(any_scalar());
      end
      push_tok(TK_AEND);
    end else begin
      push_tok(any_scalar());
    end
  endfunction

  function automatic void gen_object(int lvl);
    int n;
    n = $urandom_range(0, 3);
    push_tok(TK_OSTART);
    for (int i = 0; i < n; i++) begin
      if (i > 0) push_tok(TK_COMMA);
      // an object may follow a comma directly
      if (i > 0 && lvl < 4 && $urandom_range(0, 4) == 0) begin
        gen_object(lvl + 1);
      end else begin
        push_tok(TK_STRING);
        push_tok(TK_COLON);
        gen_value(lvl);
      end
    end
    push_tok(TK_OEND);
  endfunction

  // Chain of nested objects around the depth limit
  function automatic void gen_deep();
    int n;
    n = $urandom_range(59, 65);
    push_tok(TK_OSTART);
    repeat (n) begin
      push_tok(TK_STRING);
      push_tok(TK_COLON);
      if ($urandom_range(0, 5) == 0) begin
        push_tok(TK_NULL);
        push_tok(TK_COMMA);
      end
      push_tok(TK_OSTART);
    end
    repeat (n + 1) push_tok(TK_OEND);
  endfunction

  // Break a document now and then: bad token, early end, trailing token or noise
  function automatic void damage_doc();
    int pos;
    case ($urandom_range(0, 9))
      0: begin
        pos = $urandom_range(0, doc_q.size() - 1);
        doc_q[pos].token_kind = 4'($urandom_range(0, 15));
      end
      1: begin
        pos = $urandom_range(1, doc_q.size());
        while (doc_q.size() > pos) void'(doc_q.pop_back());
      end
      2: push_tok(4'($urandom_range(0, 15)));
      3: begin
        doc_q.delete();
        repeat ($urandom_range(1, 6)) push_tok(4'($urandom_range(0, 15)));
      end
      default: ;
    endcase
  endfunction

  initial begin : token_side
    in_item_t  it;
    out_item_t v;
    int        doc_no;
    dir_rows = '{
      '{TK_OEND,   1'b1, 1'b1, ST_FAIL, ERR_UNEXPECTED, 0},
      '{TK_OSTART, 1'b0, 1'b1, ST_BUSY, ERR_NONE,       1},
      '{TK_STRING, 1'b0, 1'b0, ST_BUSY, ERR_NONE,       0},
      '{TK_COLON,  1'b0, 1'b0, ST_BUSY, ERR_NONE,       0},
      '{TK_ASTART, 1'b0, 1'b0, ST_BUSY, ERR_NONE,       0},
      '{TK_NUMBER, 1'b0, 1'b0, ST_BUSY, ERR_NONE,       0},
      '{TK_COMMA,  1'b0, 1'b0, ST_BUSY, ERR_NONE,       0},
      '{TK_BOOL,   1'b0, 1'b0, ST_BUSY, ERR_NONE,       0},
      '{TK_AEND,   1'b0, 1'b0, ST_BUSY, ERR_NONE,       0},
      '{TK_COMMA,  1'b0, 1'b0, ST_BUSY, ERR_NONE,       0},
      '{TK_OSTART, 1'b0, 1'b0, ST_BUSY, ERR_NONE,       0},
      '{TK_STRING, 1'b0, 1'b0, ST_BUSY, ERR_NONE,       0},
      '{TK_COLON,  1'b0, 1'b0, ST_BUSY, ERR_NONE,       0},
      '{TK_NULL,   1'b0, 1'b0, ST_BUSY, ERR_NONE,       0},
      '{TK_OEND,   1'b0, 1'b0, ST_BUSY, ERR_NONE,       0},
      '{TK_OEND,   1'b0, 1'b0, ST_BUSY, ERR_NONE,       0},
      '{TK_STRING, 1'b1, 1'b1, ST_FAIL, ERR_AFTER_END,  0},
      '{TK_OSTART, 1'b0, 1'b1, ST_BUSY, ERR_NONE,       1},
      '{4'hF,      1'b0, 1'b1, ST_FAIL, ERR_UNEXPECTED, 1},
      '{TK_OSTART, 1'b1, 1'b1, ST_FAIL, ERR_UNEXPECTED, 1},
      '{TK_OSTART, 1'b1, 1'b1, ST_FAIL, ERR_UNCLOSED,   1},
      '{TK_OSTART, 1'b0, 1'b1, ST_BUSY, ERR_NONE,       1},
      '{TK_OEND,   1'b1, 1'b1, ST_OK,   ERR_NONE,       0},
      '{4'hA,      1'b1, 1'b1, ST_FAIL, ERR_UNEXPECTED, 0}
    };
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      it.token_kind = dir_rows[i].tok;
      it.last_token = dir_rows[i].is_last;
      send_token(it);
      v = predict_verdict(it);
      if (dir_rows[i].typed) begin
        v.status     = dir_rows[i].st;
        v.error_kind = dir_rows[i].er;
        v.depth      = DEPTH_W'(dir_rows[i].dep);
      end
      verdict_q.push_back(v);
    end

    doc_no = 0;
    while (items_sent < N_ITEMS) begin
      doc_q.delete();
      if (doc_no == 6 || doc_no == 31) gen_deep();
      else gen_object(1);
      damage_doc();
      doc_q[$].last_token = 1'b1;
      case ($urandom_range(0, 2))
        0:       tx_idle_pct = 0;
        1:       tx_idle_pct = 10;
        default: tx_idle_pct = 50;
      endcase
      quiet = (items_sent >= QUIET_AT);
      foreach (doc_q[i]) begin
        send_token(doc_q[i]);
        verdict_q.push_back(predict_verdict(doc_q[i]));
      end
      doc_no++;
    end
    in_valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (bad_results == 0) begin
      $display("** json_token_structure_checker_top: PASSED **");
    end else begin
      $display("** json_token_structure_checker_top: FAILED **");
    end
    $finish;
  end

  initial begin : result_side
    out_item_t want;
    int        stall_left;
    int        rx_pct;
    int        cyc;
    stall_left = 0;
    rx_pct     = 0;
    cyc        = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready) begin
        if (verdict_q.size() == 0) begin
          report_bad("result with nothing pending", '0, out_data_o);
        end else begin
          want = verdict_q.pop_front();
          if (out_data_o.status != want.status || out_data_o.error_kind != want.error_kind ||
              out_data_o.depth != want.depth)
            report_bad("mismatch", want, out_data_o);
        end
      end
      cyc++;
      if (cyc % 64 == 0) rx_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 20);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < rx_pct) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("** json_token_structure_checker_top: FAILED **");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/jtsc_pkg.sv
hdl/json_token_structure_checker_top.sv
hdl/jtsc_assert_checker.sv
verif/tb_top.sv
